// File: design/tpc_pkg.sv
// shared types and constants for the triangle plane clipper
// no dependencies
package tpc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NUM_ATTR  = 7;
    localparam int DIST_W    = 68;
    localparam int QDEPTH    = 2;

    typedef enum logic [2:0] {
        CFG_PX = 3'd0, CFG_PY = 3'd1, CFG_PZ = 3'd2,
        CFG_NX = 3'd3, CFG_NY = 3'd4, CFG_NZ = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        SLOT_0 = 2'd0, SLOT_1 = 2'd1, SLOT_2 = 2'd2, SLOT_X = 2'd3
    } slot_t;

    typedef logic signed [31:0] attr_t;
    typedef attr_t [NUM_ATTR-1:0] vattr_t;

    // classified triangle passed from front to back
    typedef struct packed {
        vattr_t [2:0]                   v;
        logic signed [2:0][DIST_W-1:0]  d;
        logic [31:0]                    color;
    } tri_t;

    typedef struct packed {
        logic [31:0] x, y, z, w, u, v, tw, color;
        logic [1:0]  corner;
        logic        tri_sel;
        logic        last;
    } res_t;

endpackage

// File: design/tpc_front.sv
// front: holds corners, computes plane distances over several cycles
// depends on tpc_pkg
module tpc_front import tpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  vattr_t      in_attr,
    input  logic [31:0] in_color,
    input  logic [1:0]  in_slot,
    output logic        q_valid,
    input  logic        q_ready,
    output tri_t        q_data
);
    typedef enum logic [2:0] {
        F_IDLE = 3'b001, F_CALC = 3'b010, F_PUSH = 3'b100
    } fstate_t;

    logic signed [31:0] pp_reg [3];
    logic signed [31:0] pn_reg [3];
    vattr_t      held_reg [2];
    fstate_t     st_reg, st_next;
    logic [1:0]  held_count_reg;
    tri_t        tri_reg;
    logic [1:0]  vi_reg;   // vertex
    logic [1:0]  ax_reg;   // axis
    logic signed [32:0] diff_reg;
    logic signed [31:0] nrm_reg;
    logic        mul_v_reg;
    logic [1:0]  mvi_reg;
    logic signed [65:0] prod;

    assign in_ready = (st_reg == F_IDLE);
    assign q_valid  = (st_reg == F_PUSH);
    assign q_data   = tri_reg;
    assign prod     = nrm_reg * diff_reg;

    always_comb begin
        st_next = st_reg;
        case (st_reg)
            F_IDLE: if (in_valid && in_slot == SLOT_2) st_next = F_CALC;
            F_CALC: if (mul_v_reg && mvi_reg == 2'd2 && ax_reg == 2'd3) st_next = F_PUSH;
            F_PUSH: if (q_ready) st_next = F_IDLE;
            default: st_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= F_IDLE;
            held_count_reg <= 2'd0;
            pp_reg[0] <= '0; pp_reg[1] <= '0; pp_reg[2] <= '0;
            pn_reg[0] <= '0; pn_reg[1] <= '0; pn_reg[2] <= 32'sd65536;
            mul_v_reg <= 1'b0;
            vi_reg <= '0;
            ax_reg <= '0;
        end else begin
            st_reg <= st_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PX: pp_reg[0] <= cfg_data;
                    CFG_PY: pp_reg[1] <= cfg_data;
                    CFG_PZ: pp_reg[2] <= cfg_data;
                    CFG_NX: pn_reg[0] <= cfg_data;
                    CFG_NY: pn_reg[1] <= cfg_data;
                    CFG_NZ: pn_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready) begin
                case (in_slot)
                    SLOT_0: held_count_reg <= 2'd1;
                    SLOT_1: held_count_reg <= 2'd2;
                    SLOT_2: held_count_reg <= 2'd0;
                    default: ;
                endcase
            end
            mul_v_reg <= 1'b0;
            if (st_reg == F_IDLE) begin
                vi_reg <= '0;
                ax_reg <= '0;
            end else if (st_reg == F_CALC && ax_reg != 2'd3) begin
                // one multiply per cycle, nine in all
                mul_v_reg <= 1'b1;
                if (ax_reg == 2'd2) begin
                    ax_reg <= (vi_reg == 2'd2) ? 2'd3 : 2'd0;
                    vi_reg <= vi_reg + 2'd1;
                end else begin
                    ax_reg <= ax_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            if (in_slot == SLOT_0) held_reg[0] <= in_attr;
            if (in_slot == SLOT_1) held_reg[1] <= in_attr;
            if (in_slot == SLOT_2) begin
                tri_reg.v[0]  <= held_reg[0];
                tri_reg.v[1]  <= held_reg[1];
                tri_reg.v[2]  <= in_attr;
                tri_reg.color <= in_color;
                tri_reg.d     <= '0;
            end
        end
        mvi_reg  <= vi_reg;
        diff_reg <= 33'(tri_reg.v[vi_reg][ax_reg]) - 33'(pp_reg[ax_reg]);
        nrm_reg  <= pn_reg[ax_reg];
        if (mul_v_reg)
            tri_reg.d[mvi_reg] <= tri_reg.d[mvi_reg] + DIST_W'(prod >>> 2);
    end

`ifndef ASSERT_OFF
    a_nopush_in_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid |-> !in_ready) else $error("front accepts while pushing");
    a_push_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        q_valid && !q_ready |=> q_valid && $stable(q_data))
        else $error("front changed queued triangle");
    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        held_count_reg != 2'd3) else $error("bad held count");
`endif
endmodule

// File: design/tpc_queue.sv
// two-entry triangle queue between front and back
// depends on tpc_pkg
module tpc_queue import tpc_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic wr_valid,
    output logic wr_ready,
    input  tri_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output tri_t rd_data
);
    tri_t       mem_reg [QDEPTH];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       wr, rd;

    assign wr_ready = (cnt_reg != 2'(QDEPTH));
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data  = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= ~wp_reg;
            if (rd) rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end

`ifndef ASSERT_OFF
    a_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 2'(QDEPTH)) else $error("queue overflow");
    a_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (cnt_reg == 2'd0 || cnt_reg == 2'(QDEPTH)) |-> wp_reg == rp_reg)
        else $error("queue pointers out of step");
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(cnt_reg) == 2'd1 && $past(rd) && !$past(wr) |-> !rd_valid)
        else $error("queue empty state wrong");
`endif
endmodule

// File: design/tpc_back.sv
// back: sort, edge fraction by restoring division, interpolation, emit
// depends on tpc_pkg
module tpc_back import tpc_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   q_valid,
    output logic   q_ready,
    input  tri_t   q_data,
    output logic   m_valid,
    input  logic   m_ready,
    output res_t   m_data
);
    typedef enum logic [6:0] {
        B_IDLE = 7'b0000001, B_SORT = 7'b0000010, B_DIV  = 7'b0000100,
        B_MUL  = 7'b0001000, B_EMIT = 7'b0010000, B_NEXT = 7'b0100000,
        B_DONE = 7'b1000000
    } bstate_t;

    localparam int TW = FRAC_BITS + 1;

    bstate_t st_reg;
    vattr_t  v_reg [3];
    logic signed [DIST_W-1:0] d_reg [3];
    logic [31:0] color_reg;
    logic [1:0]  nb_reg;      // vertices behind
    vattr_t      p_reg [2];   // edge points
    logic        e_reg;       // edge being made
    logic [DIST_W:0] num_reg, den_reg, rem_reg;
    logic [TW-1:0]   t_reg;
    logic [4:0]      it_reg;
    logic [2:0]      ak_reg;  // attribute
    logic [2:0]      oi_reg;  // output index
    logic signed [32:0] dlt_reg;
    logic        mv_reg;
    logic [2:0]  mk_reg;
    logic signed [32+TW:0] mprod;
    res_t  out_reg;
    logic  ov_reg;
    logic [DIST_W:0] da_abs, db_abs, rdbl;
    logic [1:0] ea, eb;
    vattr_t     sel;
    logic       lastv;

    function automatic logic [DIST_W:0] absd(input logic signed [DIST_W-1:0] x);
        absd = x[DIST_W-1] ? (DIST_W+1)'(-x) : (DIST_W+1)'(x);
    endfunction

    assign q_ready = (st_reg == B_IDLE);
    assign m_valid = ov_reg;
    assign m_data  = out_reg;
    assign mprod   = dlt_reg * $signed({1'b0, t_reg});

    // edge endpoints: one behind: (0,1),(0,2); two behind: (0,2),(1,2)
    always_comb begin
        ea = (nb_reg == 2'd2 && e_reg) ? 2'd1 : 2'd0;
        eb = (nb_reg == 2'd1 && !e_reg) ? 2'd1 : 2'd2;
        da_abs = absd(d_reg[ea]);
        db_abs = absd(d_reg[eb]);
        rdbl = den_reg - rem_reg;
    end

    // output order table
    always_comb begin
        sel = v_reg[0];
        lastv = 1'b0;
        if (nb_reg == 2'd0) begin
            sel = v_reg[oi_reg[1:0]];
            lastv = (oi_reg == 3'd2);
        end else if (nb_reg == 2'd1) begin
            case (oi_reg)
                3'd0: sel = p_reg[0];
                3'd1, 3'd3: sel = p_reg[1];
                3'd2, 3'd4: sel = v_reg[1];
                default: sel = v_reg[2];
            endcase
            lastv = (oi_reg == 3'd5);
        end else begin
            case (oi_reg)
                3'd0: sel = p_reg[0];
                3'd1: sel = p_reg[1];
                default: sel = v_reg[2];
            endcase
            lastv = (oi_reg == 3'd2);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= B_IDLE;
            ov_reg <= 1'b0;
            mv_reg <= 1'b0;
        end else begin
            if (ov_reg && m_ready) ov_reg <= 1'b0;
            mv_reg <= 1'b0;
            case (st_reg)
                B_IDLE: if (q_valid) st_reg <= B_SORT;
                B_SORT: begin
                    if (nb_reg == 2'd3) st_reg <= B_IDLE;
                    else if (nb_reg == 2'd0) st_reg <= B_EMIT;
                    else st_reg <= B_DIV;
                end
                B_DIV: if (it_reg == 5'(FRAC_BITS)) st_reg <= B_MUL;
                B_MUL: begin
                    if (ak_reg != 3'(NUM_ATTR)) mv_reg <= 1'b1;
                    if (ak_reg == 3'(NUM_ATTR) && !mv_reg)
                        st_reg <= e_reg ? B_EMIT : B_DIV;
                end
                B_EMIT: if (!ov_reg || m_ready) begin
                    ov_reg <= 1'b1;
                    st_reg <= lastv ? B_DONE : B_NEXT;
                end
                B_NEXT: st_reg <= B_EMIT;
                B_DONE: st_reg <= B_IDLE;
                default: st_reg <= B_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (st_reg)
            B_IDLE: begin
                for (int i = 0; i < 3; i++) begin
                    v_reg[i] <= q_data.v[i];
                    d_reg[i] <= q_data.d[i];
                end
                color_reg <= q_data.color;
                nb_reg <= 2'(q_data.d[0][DIST_W-1]) + 2'(q_data.d[1][DIST_W-1])
                        + 2'(q_data.d[2][DIST_W-1]);
                e_reg <= 1'b0;
                oi_reg <= '0;
                it_reg <= '0;
            end
            B_SORT: if (nb_reg != 2'd0) begin
                // stable three-element sorting network; pass-through keeps input order
                if (d_reg[0] > d_reg[1]) begin
                    if (d_reg[1] > d_reg[2]) begin
                        v_reg[0] <= v_reg[2]; d_reg[0] <= d_reg[2];
                        v_reg[2] <= v_reg[0]; d_reg[2] <= d_reg[0];
                    end else if (d_reg[0] > d_reg[2]) begin
                        v_reg[0] <= v_reg[1]; d_reg[0] <= d_reg[1];
                        v_reg[1] <= v_reg[2]; d_reg[1] <= d_reg[2];
                        v_reg[2] <= v_reg[0]; d_reg[2] <= d_reg[0];
                    end else begin
                        v_reg[0] <= v_reg[1]; d_reg[0] <= d_reg[1];
                        v_reg[1] <= v_reg[0]; d_reg[1] <= d_reg[0];
                    end
                end else if (d_reg[1] > d_reg[2]) begin
                    if (d_reg[0] > d_reg[2]) begin
                        v_reg[0] <= v_reg[2]; d_reg[0] <= d_reg[2];
                        v_reg[1] <= v_reg[0]; d_reg[1] <= d_reg[0];
                        v_reg[2] <= v_reg[1]; d_reg[2] <= d_reg[1];
                    end else begin
                        v_reg[1] <= v_reg[2]; d_reg[1] <= d_reg[2];
                        v_reg[2] <= v_reg[1]; d_reg[2] <= d_reg[1];
                    end
                end
            end
            B_DIV: begin
                if (it_reg == 5'd0) begin
                    num_reg <= da_abs;
                    den_reg <= da_abs + db_abs;
                    rem_reg <= da_abs;
                    t_reg <= '0;
                    it_reg <= 5'd1;
                end else if (it_reg <= 5'(FRAC_BITS)) begin
                    if (den_reg == '0 || num_reg >= den_reg) begin
                        t_reg <= TW'(1) << FRAC_BITS;
                        it_reg <= 5'(FRAC_BITS);
                    end else begin
                        if (rem_reg >= rdbl) begin
                            rem_reg <= rem_reg - rdbl;
                            t_reg <= {t_reg[TW-2:0], 1'b1};
                        end else begin
                            rem_reg <= rem_reg + rem_reg;
                            t_reg <= {t_reg[TW-2:0], 1'b0};
                        end
                        it_reg <= it_reg + 5'd1;
                    end
                end
                ak_reg <= '0;
            end
            B_MUL: begin
                if (ak_reg != 3'(NUM_ATTR)) begin
                    dlt_reg <= 33'(v_reg[eb][ak_reg]) - 33'(v_reg[ea][ak_reg]);
                    mk_reg <= ak_reg;
                    ak_reg <= ak_reg + 3'd1;
                end
                if (mv_reg)
                    p_reg[e_reg][mk_reg] <= v_reg[ea][mk_reg]
                        + 32'(mprod >>> FRAC_BITS);
                if (ak_reg == 3'(NUM_ATTR) && !mv_reg) begin
                    e_reg <= 1'b1;
                    it_reg <= '0;
                end
            end
            B_EMIT: if (!ov_reg || m_ready) begin
                out_reg.x <= sel[0]; out_reg.y <= sel[1]; out_reg.z <= sel[2];
                out_reg.w <= sel[3]; out_reg.u <= sel[4]; out_reg.v <= sel[5];
                out_reg.tw <= sel[6];
                out_reg.color <= color_reg;
                out_reg.corner <= (nb_reg == 2'd1 && oi_reg >= 3'd3)
                    ? 2'(oi_reg - 3'd3) : oi_reg[1:0];
                out_reg.tri_sel <= (nb_reg == 2'd1 && oi_reg >= 3'd3);
                out_reg.last <= lastv;
            end
            B_NEXT: oi_reg <= oi_reg + 3'd1;
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");
    a_tsize: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg == B_MUL |-> t_reg <= (TW'(1) << FRAC_BITS))
        else $error("edge fraction above one");
    a_corner: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.corner != 2'd3) else $error("bad corner");
`endif
endmodule

// File: design/triangle_plane_clipper_core.sv
// triangle plane clipper: front computes distances serially and takes slot 0/1
// items while idle; back sorts, divides each edge bit by bit and interpolates it,
// then emits the vertex words, taking a new triangle only when done with the last;
// a clipped triangle's time in the back is bound by the bit-serial edge divider.
// aresetn is synchronous active low; plane resets to point 0, normal (0,0,1).
// depends on tpc_pkg, tpc_front, tpc_queue, tpc_back
module triangle_plane_clipper_core import tpc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_vertex_x,
    input  logic [31:0] s_vertex_y,
    input  logic [31:0] s_vertex_z,
    input  logic [31:0] s_vertex_w,
    input  logic [31:0] s_tex_u,
    input  logic [31:0] s_tex_v,
    input  logic [31:0] s_tex_w,
    input  logic [31:0] s_tri_color,
    input  logic [1:0]  s_vertex_slot,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_out_x,
    output logic [31:0] m_out_y,
    output logic [31:0] m_out_z,
    output logic [31:0] m_out_w,
    output logic [31:0] m_out_u,
    output logic [31:0] m_out_v,
    output logic [31:0] m_out_tex_w,
    output logic [31:0] m_out_color,
    output logic [1:0]  m_out_corner,
    output logic        m_out_triangle,
    output logic        m_last_of_run
);
    vattr_t attr;
    logic   fq_valid, fq_ready, qb_valid, qb_ready;
    tri_t   fq_data, qb_data;
    res_t   res;

    assign attr[0] = s_vertex_x; assign attr[1] = s_vertex_y;
    assign attr[2] = s_vertex_z; assign attr[3] = s_vertex_w;
    assign attr[4] = s_tex_u;    assign attr[5] = s_tex_v;
    assign attr[6] = s_tex_w;

    tpc_front u_front (
        .aclk, .aresetn, .cfg_we, .cfg_index, .cfg_data,
        .in_valid(s_valid), .in_ready(s_ready), .in_attr(attr),
        .in_color(s_tri_color), .in_slot(s_vertex_slot),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_data(fq_data)
    );

    tpc_queue u_queue (
        .aclk, .aresetn,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_data),
        .rd_valid(qb_valid), .rd_ready(qb_ready), .rd_data(qb_data)
    );

    tpc_back u_back (
        .aclk, .aresetn,
        .q_valid(qb_valid), .q_ready(qb_ready), .q_data(qb_data),
        .m_valid, .m_ready, .m_data(res)
    );

    assign m_out_x = res.x;  assign m_out_y = res.y;  assign m_out_z = res.z;
    assign m_out_w = res.w;  assign m_out_u = res.u;  assign m_out_v = res.v;
    assign m_out_tex_w = res.tw;
    assign m_out_color = res.color;
    assign m_out_corner = res.corner;
    assign m_out_triangle = res.tri_sel;
    assign m_last_of_run = res.last;
endmodule

// File: tb/triangle_plane_clipper_core_tb.sv
// testbench for triangle_plane_clipper_core: drives vertex words and plane registers,
// predicts the clipped vertex words and checks them in order
// depends on tpc_pkg and the clipper rtl
`timescale 1ns / 1ps

module triangle_plane_clipper_core_tb;
    import tpc_pkg::*;

    typedef struct {
        logic signed [63:0] a [NUM_ATTR];
        logic signed [67:0] sdist;
    } vert_t;

    typedef struct {
        logic [31:0] a [NUM_ATTR];
        logic [31:0] color;
        logic [1:0]  corner;
        logic        tri_sel;
        logic        last;
    } vword_t;

    class clip_scoreboard;
        logic [31:0] plane [6];
        logic [31:0] held [2][NUM_ATTR];
        vword_t      pending [$];
        int          errors;

        function new();
            foreach (plane[i]) plane[i] = 0;
            plane[CFG_NZ] = 32'h0001_0000;
            foreach (held[i, k]) held[i][k] = 0;
            errors = 0;
        endfunction

        function logic signed [67:0] distance(vert_t v);
            logic signed [67:0] sum;
            logic signed [67:0] diff;
            logic signed [67:0] prod;
            sum = 0;
            for (int k = 0; k < 3; k++) begin
                diff = v.a[k] - 68'(signed'(plane[k]));
                prod = 68'(signed'(plane[3 + k])) * diff;
                sum += prod >>> 2;
            end
            return sum;
        endfunction

        function logic [63:0] edge_fraction(logic signed [67:0] da, logic signed [67:0] db);
            logic [67:0]  num;
            logic [67:0]  den;
            logic [127:0] scaled;
            num = da < 0 ? -da : da;
            den = num + (db < 0 ? -db : db);
            if (den == 0 || num >= den) return 64'd1 << FRAC_BITS;
            scaled = 128'(num) << FRAC_BITS;
            return 64'(scaled / den);
        endfunction

        function vert_t lerp(vert_t a, vert_t b, logic [63:0] t);
            vert_t r;
            logic signed [127:0] prod;
            for (int k = 0; k < NUM_ATTR; k++) begin
                prod = 128'(b.a[k] - a.a[k]) * $signed({1'b0, t});
                r.a[k] = a.a[k] + 64'(prod >>> FRAC_BITS);
            end
            r.sdist = 0;
            return r;
        endfunction

        function void push(vert_t v, logic [31:0] color, int corner, int tri_sel, int last);
            vword_t w;
            for (int k = 0; k < NUM_ATTR; k++) w.a[k] = v.a[k][31:0];
            w.color = color;
            w.corner = corner[1:0];
            w.tri_sel = tri_sel[0];
            w.last = last[0];
            pending.push_back(w);
        endfunction

        function void note_input(logic [31:0] attr [NUM_ATTR], logic [31:0] color,
                                 logic [1:0] slot);
            vert_t v [3];
            vert_t tmp;
            vert_t p0;
            vert_t p1;
            int behind;
            int j;
            if (slot == SLOT_X) return;
            if (slot != SLOT_2) begin
                for (int k = 0; k < NUM_ATTR; k++) held[slot][k] = attr[k];
                return;
            end
            behind = 0;
            for (int i = 0; i < 3; i++) begin
                for (int k = 0; k < NUM_ATTR; k++)
                    v[i].a[k] = signed'(i < 2 ? held[i][k] : attr[k]);
                v[i].sdist = distance(v[i]);
                if (v[i].sdist < 0) behind++;
            end
            if (behind == 3) return;
            if (behind == 0) begin
                for (int i = 0; i < 3; i++) push(v[i], color, i, 0, i == 2);
                return;
            end
            for (int i = 1; i < 3; i++) begin
                tmp = v[i];
                j = i - 1;
                while (j >= 0 && v[j].sdist > tmp.sdist) begin
                    v[j + 1] = v[j];
                    j--;
                end
                v[j + 1] = tmp;
            end
            if (behind == 1) begin
                p0 = lerp(v[0], v[1], edge_fraction(v[0].sdist, v[1].sdist));
                p1 = lerp(v[0], v[2], edge_fraction(v[0].sdist, v[2].sdist));
                push(p0, color, 0, 0, 0);
                push(p1, color, 1, 0, 0);
                push(v[1], color, 2, 0, 0);
                push(p1, color, 0, 1, 0);
                push(v[1], color, 1, 1, 0);
                push(v[2], color, 2, 1, 1);
            end else begin
                p0 = lerp(v[0], v[2], edge_fraction(v[0].sdist, v[2].sdist));
                p1 = lerp(v[1], v[2], edge_fraction(v[1].sdist, v[2].sdist));
                push(p0, color, 0, 0, 0);
                push(p1, color, 1, 0, 0);
                push(v[2], color, 2, 0, 1);
            end
        endfunction

        function void check_result(vword_t got);
            vword_t exp_w;
            bit bad;
            if (pending.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected word x=%h", got.a[0]);
                return;
            end
            exp_w = pending.pop_front();
            bad = (got.color !== exp_w.color) || (got.corner !== exp_w.corner) ||
                  (got.tri_sel !== exp_w.tri_sel) || (got.last !== exp_w.last);
            for (int k = 0; k < NUM_ATTR; k++)
                if (got.a[k] !== exp_w.a[k]) bad = 1;
            if (bad) begin
                errors++;
                if (errors <= 10) begin
                    $display("mismatch exp: %h %h %h %h %h %h %h c=%h k=%0d t=%0d l=%0d",
                             exp_w.a[0], exp_w.a[1], exp_w.a[2], exp_w.a[3], exp_w.a[4],
                             exp_w.a[5], exp_w.a[6], exp_w.color, exp_w.corner,
                             exp_w.tri_sel, exp_w.last);
                    $display("         got: %h %h %h %h %h %h %h c=%h k=%0d t=%0d l=%0d",
                             got.a[0], got.a[1], got.a[2], got.a[3], got.a[4],
                             got.a[5], got.a[6], got.color, got.corner,
                             got.tri_sel, got.last);
                end
            end
        endfunction
    endclass

    localparam int WATCHDOG_LIMIT = 20000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        s_valid;
    logic        s_ready;
    logic [31:0] s_vertex_x, s_vertex_y, s_vertex_z, s_vertex_w;
    logic [31:0] s_tex_u, s_tex_v, s_tex_w, s_tri_color;
    logic [1:0]  s_vertex_slot;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_out_x, m_out_y, m_out_z, m_out_w, m_out_u, m_out_v, m_out_tex_w;
    logic [31:0] m_out_color;
    logic [1:0]  m_out_corner;
    logic        m_out_triangle;
    logic        m_last_of_run;

    triangle_plane_clipper_core dut (.*);

    clip_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int idle_cycles;
    bit timed_out;

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    // result side: sample at rising edge, change ready at falling edge
    always @(posedge aclk) begin
        vword_t got;
        if (aresetn && m_valid && m_ready) begin
            got.a[0] = m_out_x; got.a[1] = m_out_y; got.a[2] = m_out_z;
            got.a[3] = m_out_w; got.a[4] = m_out_u; got.a[5] = m_out_v;
            got.a[6] = m_out_tex_w;
            got.color = m_out_color;
            got.corner = m_out_corner;
            got.tri_sel = m_out_triangle;
            got.last = m_last_of_run;
            sb.check_result(got);
        end
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
    end

    always @(negedge aclk)
        m_ready <= ($urandom_range(99) >= recv_stall_pct);

    task automatic write_reg(cfg_idx_t idx, logic [31:0] value);
        s_valid <= 0;
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_data <= value;
        sb.plane[idx] = value;
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    // valid stays high after acceptance until the next word or an idle cycle drops it
    task automatic send_vertex(logic [31:0] attr [NUM_ATTR], logic [31:0] color,
                               logic [1:0] slot);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(negedge aclk);
        end
        s_valid <= 1;
        s_vertex_x <= attr[0]; s_vertex_y <= attr[1]; s_vertex_z <= attr[2];
        s_vertex_w <= attr[3]; s_tex_u <= attr[4]; s_tex_v <= attr[5];
        s_tex_w <= attr[6];
        s_tri_color <= color;
        s_vertex_slot <= slot;
        do @(posedge aclk); while (!s_ready);
        sb.note_input(attr, color, slot);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (200) @(negedge aclk);
    endtask

    // small coordinates keep triangles straddling the plane; some full-range noise
    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return 32'($signed($urandom_range(8 << 16)) - (4 << 16));
            default: return $urandom_range(3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    task automatic send_triangle(int mode);
        logic [31:0] attr [NUM_ATTR];
        for (int s = 0; s < 3; s++) begin
            for (int k = 0; k < NUM_ATTR; k++)
                attr[k] = (k < 3) ? rand_coord(mode) : $urandom();
            send_vertex(attr, $urandom(), s[1:0]);
        end
    endtask

    task automatic random_plane(bit extreme);
        for (int r = 0; r < 6; r++)
            write_reg(cfg_idx_t'(r), extreme ? ($urandom_range(1) ? 32'h8000_0000
                                                                   : 32'h7fff_ffff)
                                             : rand_coord(1));
    endtask

    task automatic directed();
        logic [31:0] attr [NUM_ATTR];
        int zs [4][3] = '{'{1, 2, 3}, '{-1, -2, -3}, '{-1, 2, 3}, '{-1, -2, 3}};
        foreach (zs[t]) begin
            for (int s = 0; s < 3; s++) begin
                for (int k = 0; k < NUM_ATTR; k++) attr[k] = $urandom();
                attr[0] = s << 16;
                attr[2] = zs[t][s] << 16;
                send_vertex(attr, 32'hc0de_0000 | t, s[1:0]);
            end
        end
        // ignored slot, then extremes of every field
        send_vertex(attr, 32'hffff_ffff, SLOT_X);
        for (int s = 0; s < 3; s++) begin
            for (int k = 0; k < NUM_ATTR; k++) attr[k] = s[0] ? 32'h8000_0000 : 32'h7fff_ffff;
            send_vertex(attr, s[0] ? 32'h0 : 32'hffff_ffff, s[1:0]);
        end
        drain();
        // zero normal: everything passes
        write_reg(CFG_NZ, 0);
        send_triangle(0);
        drain();
    endtask

    initial begin
        sb = new();
        aresetn = 0;
        cfg_we = 0; cfg_index = 0; cfg_data = 0;
        s_valid = 0; s_vertex_slot = 0;
        s_vertex_x = 0; s_vertex_y = 0; s_vertex_z = 0; s_vertex_w = 0;
        s_tex_u = 0; s_tex_v = 0; s_tex_w = 0; s_tri_color = 0;
        m_ready = 0;
        send_idle_pct = 0; recv_stall_pct = 0;
        timed_out = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;
        write_reg(CFG_NZ, 32'h0001_0000);
        directed();
        for (int phase = 0; phase < 8; phase++) begin
            case (phase % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            random_plane(phase == 5);
            for (int t = 0; t < 13; t++) begin
                if ($urandom_range(19) == 0) send_vertex('{default: $urandom()}, $urandom(),
                                                         SLOT_X);
                send_triangle($urandom_range(9) == 0 ? 0 : ($urandom_range(19) == 0 ? 2 : 1));
                if (t == 6) drain();
            end
            drain();
        end
        send_idle_pct = 0; recv_stall_pct = 0;
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) $display("SUCCESS");
        else $display("FAILURE");
        $finish;
    end

    initial begin
        wait (aresetn);
        wait (idle_cycles >= WATCHDOG_LIMIT);
        $display("FAILURE");
        $finish;
    end

endmodule

// File: filelist.f
design/tpc_pkg.sv
design/tpc_front.sv
design/tpc_queue.sv
design/tpc_back.sv
design/triangle_plane_clipper_core.sv
tb/triangle_plane_clipper_core_tb.sv
